/* hw/rtl/amgt_pkg.sv */
`default_nettype none
package amgt_pkg;
  localparam int MaxVertices = 16;
  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int AddrW = 2 * IdxW;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_SET  = 2'd1,
    REQ_READ = 2'd2,
    REQ_DEG  = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    req_t        req;
    logic [15:0] key_a;
    logic [15:0] key_b;
    logic [15:0] weight;
  } item_t;

  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  status;
  } res_t;
endpackage
`default_nettype wire

/* hw/rtl/amgt_front.sv */
`default_nettype none
module amgt_front import amgt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        clr,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire item_t       in_item,
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);
  // Two-entry queue decoupling acceptance from the engine.
  item_t           mem_r [QDepth];
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready = (cnt_r != 2'(QDepth));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    if (clr) begin
      wp_nxt = 1'b0; rp_nxt = 1'b0; cnt_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= in_item;
  end
endmodule
`default_nettype wire

/* hw/rtl/amgt_back.sv */
`default_nettype none
module amgt_back import amgt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_null,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire item_t       q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FINDA = 7'b0000010,
    S_FINDB = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WR2   = 7'b0010000,
    S_DEG   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] keys_r [MaxVertices];
  logic [15:0] mat_r [MaxVertices*MaxVertices];
  logic [MaxVertices*MaxVertices-1:0] vld_r;
  logic [15:0] null_r;
  logic [CntW-1:0] vcnt_r;
  item_t it_r;
  logic [CntW-1:0] i_r, i_nxt;
  logic [IdxW-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [15:0] val_r, val_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [15:0] rd_r;
  logic        rd_v_r;
  logic [AddrW-1:0] ra, wa;
  logic [15:0] wd, key_i, cur;
  logic        we, hit, rd_en;

  assign key_i = keys_r[i_r[IdxW-1:0]];
  assign cur = rd_v_r ? rd_r : null_r;
  assign q_ready = (state_r == S_IDLE) && !cfg_we;
  assign out_valid = (state_r == S_OUT);
  assign out_res = '{value: val_r, status: st_r};

  always_comb begin
    state_nxt = state_r; i_nxt = i_r; row_nxt = row_r; col_nxt = col_r;
    val_nxt = val_r; st_nxt = st_r;
    we = 1'b0; wa = '0; wd = it_r.weight; rd_en = 1'b0; ra = '0;
    hit = 1'b0;
    unique case (state_r)
      S_IDLE: if (q_valid && q_ready) begin
        i_nxt = '0; val_nxt = '0; st_nxt = ST_OK;
        if (q_item.req == REQ_ADD) state_nxt = S_OUT;
        else state_nxt = S_FINDA;
      end
      S_FINDA: begin
        hit = (i_r < vcnt_r) && (key_i == it_r.key_a);
        if (hit) begin
          row_nxt = i_r[IdxW-1:0]; i_nxt = '0;
          if (it_r.req == REQ_DEG) begin
            state_nxt = S_DEG; rd_en = 1'b1;
            ra = {i_r[IdxW-1:0], {IdxW{1'b0}}};
          end else state_nxt = S_FINDB;
        end else if (i_r >= vcnt_r) begin
          st_nxt = ST_NOTFOUND; state_nxt = S_OUT;
        end else i_nxt = i_r + 1'b1;
      end
      S_FINDB: begin
        hit = (i_r < vcnt_r) && (key_i == it_r.key_b);
        if (hit) begin
          col_nxt = i_r[IdxW-1:0];
          if (it_r.req == REQ_SET) begin
            we = 1'b1; wa = {row_r, i_r[IdxW-1:0]}; state_nxt = S_WR2;
          end else begin
            rd_en = 1'b1; ra = {row_r, i_r[IdxW-1:0]}; state_nxt = S_RD;
          end
        end else if (i_r >= vcnt_r) begin
          st_nxt = ST_NOTFOUND; state_nxt = S_OUT;
        end else i_nxt = i_r + 1'b1;
      end
      S_WR2: begin
        we = 1'b1; wa = {col_r, row_r}; state_nxt = S_OUT;
      end
      S_RD: begin
        val_nxt = cur; state_nxt = S_OUT;
      end
      S_DEG: begin
        // Row entries are read one per cycle; entry i_r-1 is counted while entry i_r is read.
        if (i_r != '0) val_nxt = val_r + {15'd0, cur != null_r};
        if (i_r == CntW'(MaxVertices)) state_nxt = S_OUT;
        else begin
          rd_en = 1'b1; ra = {row_r, i_r[IdxW-1:0]};
          i_nxt = i_r + 1'b1;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; vcnt_r <= '0; null_r <= '0; vld_r <= '0; rd_v_r <= 1'b0;
    end else if (cfg_we) begin
      state_r <= S_IDLE; vcnt_r <= '0; null_r <= cfg_null; vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && q_valid && q_item.req == REQ_ADD &&
          vcnt_r != CntW'(MaxVertices))
        vcnt_r <= vcnt_r + 1'b1;
      if (we) vld_r[wa] <= 1'b1;
      if (rd_en) rd_v_r <= vld_r[ra];
    end
    if (state_r == S_IDLE && q_valid && q_ready) begin
      it_r <= q_item;
      if (q_item.req == REQ_ADD) begin
        if (vcnt_r == CntW'(MaxVertices)) st_r <= ST_FULL;
        else begin
          st_r <= ST_OK;
          keys_r[vcnt_r[IdxW-1:0]] <= q_item.key_a;
        end
        val_r <= '0;
      end else begin
        st_r <= st_nxt; val_r <= val_nxt;
      end
    end else begin
      st_r <= st_nxt; val_r <= val_nxt;
    end
    i_r <= i_nxt; row_r <= row_nxt; col_r <= col_nxt;
    if (we) mat_r[wa] <= wd;
    if (rd_en) rd_r <= mat_r[ra];
  end
endmodule
`default_nettype wire

/* hw/rtl/adjacency_matrix_graph_table_top.sv */
`default_nettype none
// Weighted undirected graph store with 16 vertices. Requests enter a two-entry
// queue and are run one at a time by a lookup engine that compares one stored
// key per cycle: an add needs no key scan, a read or set takes two key scans,
// and a degree request takes a key scan followed by reads of all 16 entries of
// its row in the matrix memory. Writing null_weight empties the graph at once
// through per-entry valid bits; write it only while the block is idle.
module adjacency_matrix_graph_table_top import amgt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // key_a[15:0], key_b[31:16], weight[47:32]
  input  wire logic [1:0]  in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // value
  output logic [1:0]       out_tuser  // status
);
  item_t it, q_item;
  res_t  res;
  logic  q_valid, q_ready;

  assign it = '{req: req_t'(in_tuser), key_a: in_tdata[15:0], key_b: in_tdata[31:16],
                weight: in_tdata[47:32]};

  amgt_front u_front (
    .clk(clk), .rst_n(rst_n), .clr(cfg_we), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(it), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  amgt_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_null(cfg_wdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = res.value;
  assign out_tuser = res.status;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3) else $error("bad status code");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> out_tdata == 16'd0)
    else $error("error result carries a value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_we)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire
